>>> rtl/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_FIN_CLEAR  = 3'd0;
    localparam logic [2:0] ERR_RSV_SET    = 3'd1;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd2;
    localparam logic [2:0] ERR_NO_MASK    = 3'd3;
    localparam logic [2:0] ERR_DEGEN_MASK = 3'd4;

    // Register map: one 32-bit register per word
    localparam int          PADDR_W          = 3;
    localparam logic        REG_MAX_PAYLOAD  = 1'b0;
    localparam logic [31:0] MAX_PAYLOAD_INIT = 32'd65536;

    // One result request
    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  payload_byte;
        logic [3:0]  frame_opcode;
        logic [31:0] frame_length;
        logic        last_byte;
        logic [2:0]  error_code;
    } wsd_result_t;

endpackage

>>> rtl/wsd_in_if.sv
// Byte stream channel into the deframer.
interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       frame_start;

    modport source (output valid, stream_byte, frame_start, input ready);
    modport sink   (input valid, stream_byte, frame_start, output ready);
endinterface

>>> rtl/wsd_out_if.sv
// Result channel out of the deframer.
interface wsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic [31:0] frame_length;
    logic        last_byte;
    logic [2:0]  error_code;

    modport source (output valid, result_kind, payload_byte, frame_opcode, frame_length,
                    last_byte, error_code, input ready);
    modport sink   (input valid, result_kind, payload_byte, frame_opcode, frame_length,
                    last_byte, error_code, output ready);
endinterface

>>> rtl/wsd_parser.sv
// Frame parser: parse state registers and the per-byte next-state and result logic.
module wsd_parser
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  stream_byte,
    input  logic        frame_start,
    input  logic [31:0] max_len,
    output logic        res_hit,
    output wsd_result_t res
);

    localparam logic [2:0] PH_HEAD0   = 3'd0;
    localparam logic [2:0] PH_HEAD1   = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DROP    = 3'd5;

    localparam logic [6:0] CODE_LEN16 = 7'd126;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        masked_reg, masked_next;
    logic [6:0]  code_reg, code_next;
    logic [2:0]  ext_cnt_reg, ext_cnt_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  key_cnt_reg, key_cnt_next;
    logic [31:0] pay_cnt_reg, pay_cnt_next;

    logic [2:0]  phase_cur;
    logic        len_done;
    logic [2:0]  ext_need;
    logic [7:0]  key_byte;
    logic        is_last;

    // Byte with frame_start restarts at the first header byte
    assign phase_cur = frame_start ? PH_HEAD0 : phase_reg;
    assign ext_need  = (code_reg == CODE_LEN16) ? 3'd2 : 3'd0;

    // Pick the key byte for this payload position, first key byte on top
    always_comb
    begin
        case (pay_cnt_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign is_last = (len_reg[63:32] == 32'd0) &&
                     (({1'b0, pay_cnt_reg} + 33'd1) >= {1'b0, len_reg[31:0]});

    // Next state and result for one byte
    always_comb
    begin
        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        masked_next  = masked_reg;
        code_next    = code_reg;
        ext_cnt_next = ext_cnt_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        key_cnt_next = key_cnt_reg;
        pay_cnt_next = pay_cnt_reg;
        len_done     = 1'b0;
        res_hit      = 1'b0;
        res          = '0;

        case (phase_cur)
            PH_HEAD0:
            begin
                opcode_next  = stream_byte[3:0];
                masked_next  = 1'b0;
                code_next    = 7'd0;
                ext_cnt_next = 3'd0;
                len_next     = 64'd0;
                key_next     = 32'd0;
                key_cnt_next = 2'd0;
                pay_cnt_next = 32'd0;
                if (!stream_byte[7])
                begin
                    phase_next     = PH_DROP;
                    res_hit        = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_FIN_CLEAR;
                end
                else if (stream_byte[6:4] != 3'd0)
                begin
                    phase_next     = PH_DROP;
                    res_hit        = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_RSV_SET;
                end
                else
                begin
                    phase_next = PH_HEAD1;
                end
            end
            PH_HEAD1:
            begin
                masked_next = stream_byte[7];
                code_next   = stream_byte[6:0];
                if (stream_byte[6:0] < CODE_LEN16)
                begin
                    len_next = {57'd0, stream_byte[6:0]};
                    len_done = 1'b1;
                end
                else
                begin
                    len_next     = 64'd0;
                    ext_cnt_next = 3'd0;
                    phase_next   = PH_EXTLEN;
                end
            end
            PH_EXTLEN:
            begin
                len_next     = {len_reg[55:0], stream_byte};
                ext_cnt_next = ext_cnt_reg + 3'd1;
                len_done     = (ext_cnt_next == ext_need);
            end
            PH_KEY:
            begin
                key_next     = {key_reg[23:0], stream_byte};
                key_cnt_next = key_cnt_reg + 2'd1;
                if (key_cnt_next == 2'd0)
                begin
                    res_hit = 1'b1;
                    if ((len_reg != 64'd0) && ((key_next == 32'd0) || (&key_next)))
                    begin
                        phase_next      = PH_DROP;
                        res.result_kind = KIND_ERROR;
                        res.error_code  = ERR_DEGEN_MASK;
                    end
                    else
                    begin
                        pay_cnt_next     = 32'd0;
                        phase_next       = (len_reg != 64'd0) ? PH_PAYLOAD : PH_HEAD0;
                        res.result_kind  = KIND_HEADER;
                        res.frame_length = len_reg[31:0];
                    end
                end
            end
            PH_PAYLOAD:
            begin
                pay_cnt_next = pay_cnt_reg + 32'd1;
                if (is_last)
                begin
                    phase_next = PH_HEAD0;
                end
                res_hit          = 1'b1;
                res.result_kind  = KIND_PAYLOAD;
                res.payload_byte = stream_byte ^ key_byte;
                res.frame_length = len_reg[31:0];
                res.last_byte    = is_last;
            end
            default:
            begin
                phase_next = PH_DROP;
            end
        endcase

        // Length complete: check limit and mask, then go to key or end empty frame
        if (len_done)
        begin
            if ((len_next[63:32] != 32'd0) || (len_next[31:0] > max_len))
            begin
                phase_next      = PH_DROP;
                res_hit         = 1'b1;
                res.result_kind = KIND_ERROR;
                res.error_code  = ERR_TOO_LONG;
            end
            else if (masked_next)
            begin
                phase_next   = PH_KEY;
                key_cnt_next = 2'd0;
                key_next     = 32'd0;
            end
            else if (len_next != 64'd0)
            begin
                phase_next      = PH_DROP;
                res_hit         = 1'b1;
                res.result_kind = KIND_ERROR;
                res.error_code  = ERR_NO_MASK;
            end
            else
            begin
                phase_next      = PH_HEAD0;
                res_hit         = 1'b1;
                res.result_kind = KIND_HEADER;
            end
        end

        res.frame_opcode = opcode_next;
    end

    // Advance parse state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEAD0;
            opcode_reg  <= 4'd0;
            masked_reg  <= 1'b0;
            code_reg    <= 7'd0;
            ext_cnt_reg <= 3'd0;
            len_reg     <= 64'd0;
            key_reg     <= 32'd0;
            key_cnt_reg <= 2'd0;
            pay_cnt_reg <= 32'd0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            opcode_reg  <= opcode_next;
            masked_reg  <= masked_next;
            code_reg    <= code_next;
            ext_cnt_reg <= ext_cnt_next;
            len_reg     <= len_next;
            key_reg     <= key_next;
            key_cnt_reg <= key_cnt_next;
            pay_cnt_reg <= pay_cnt_next;
        end
    end

    // An error always leaves the parser dropping bytes
    a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_hit && (res.result_kind == KIND_ERROR)) |=> (phase_reg == PH_DROP))
        else $error("error result did not move parser to drop");

    // Payload position never runs past the decoded length
    a_payload_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> ({32'd0, pay_cnt_reg} < len_reg))
        else $error("payload count reached frame length while in payload");

    // Last mark only rides on payload results
    a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_hit && res.last_byte) |-> (res.result_kind == KIND_PAYLOAD))
        else $error("last mark on a non-payload result");

endmodule

>>> rtl/wsd_out_buf.sv
// Output register with a skid stage for result requests.
module wsd_out_buf
    import wsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  wsd_result_t push_data,
    output logic        can_push,
    output logic        out_valid,
    input  logic        out_ready,
    output wsd_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    wsd_result_t out_data_reg, out_data_next;
    wsd_result_t skid_data_reg, skid_data_next;
    logic        out_fire;

    assign out_fire  = out_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Fill the output slot first, park in skid when the output stalls
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payloads
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Skid stage only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full with empty output register");

    // A parked request stays until the output drains
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_ready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid request lost while output stalled");

    // A stalled output request holds valid and payload
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("output request changed while stalled");

endmodule

>>> rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: APB register, parser and output buffer.
//
//  Channel   Dir   Handshake        Payload
//  byte_ch   in    valid/ready      stream_byte[7:0], frame_start
//  result_ch out   valid/ready      result_kind, payload_byte, frame_opcode,
//                                   frame_length, last_byte, error_code
//  apb       in    psel/penable     reg 0 max_payload_bytes at 0x0
//
// One byte per cycle while byte_ch.ready is high: each accepted byte is parsed in the
// cycle it is taken; its result, if any, is registered in the output or skid stage.
// Rate is set by the single parse step plus a two-entry output buffer; byte_ch.ready
// drops only while both output entries are full.
// rst_n is asynchronous: parser returns to waiting for the first header byte and
// max_payload_bytes returns to 65536. No clearing pass is needed.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    wsd_in_if.sink             byte_ch,
    wsd_out_if.source          result_ch
);

    logic [31:0] max_len_reg;
    logic        take;
    logic        res_hit;
    logic        can_push;
    wsd_result_t res;
    wsd_result_t out_data;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? max_len_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_PAYLOAD_INIT;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD))
        begin
            max_len_reg <= pwdata;
        end
    end

    // Accept a byte while the output buffer has room
    assign byte_ch.ready = can_push;
    assign take          = byte_ch.valid && can_push;

    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .stream_byte (byte_ch.stream_byte),
        .frame_start (byte_ch.frame_start),
        .max_len     (max_len_reg),
        .res_hit     (res_hit),
        .res         (res)
    );

    wsd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_hit),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .out_data  (out_data)
    );

    // Drive result fields
    assign result_ch.result_kind  = out_data.result_kind;
    assign result_ch.payload_byte = out_data.payload_byte;
    assign result_ch.frame_opcode = out_data.frame_opcode;
    assign result_ch.frame_length = out_data.frame_length;
    assign result_ch.last_byte    = out_data.last_byte;
    assign result_ch.error_code   = out_data.error_code;

endmodule

>>> sim/wsd_frame_checker.sv
`timescale 1ns / 100ps
// Frame checker: predicts deframer results from accepted bytes and compares returned results.
module wsd_frame_checker
    import wsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    wsd_in_if                  byte_ch,
    wsd_out_if                 result_ch,
    output int                 mismatches,
    output int                 outstanding
);

    typedef enum logic [2:0] {ST_HDR0, ST_HDR1, ST_EXTLEN, ST_KEY, ST_DATA, ST_DROP} parse_st_t;

    localparam logic [PADDR_W-1:0] MAX_PAYLOAD_ADDR = PADDR_W'(4 * int'(REG_MAX_PAYLOAD));
    localparam logic [6:0]         LEN_CODE_16      = 7'd126;

    // Shadow parser state and limit register
    parse_st_t   st;
    logic [3:0]  opcode;
    logic        masked;
    logic [6:0]  len_code;
    logic [2:0]  ext_seen;
    logic [63:0] frame_len;
    logic [31:0] key;
    logic [1:0]  key_seen;
    logic [31:0] data_cnt;
    logic [31:0] limit;

    wsd_result_t expected_q[$];
    wsd_result_t head;
    int          fail_cnt = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    task automatic queue_result(input logic [1:0] kind, input logic [7:0] pbyte,
                                input logic [31:0] len, input logic last,
                                input logic [2:0] code);
        wsd_result_t r;
        r.result_kind  = kind;
        r.payload_byte = pbyte;
        r.frame_opcode = opcode;
        r.frame_length = len;
        r.last_byte    = last;
        r.error_code   = code;
        expected_q.push_back(r);
    endtask

    task automatic raise_error(input logic [2:0] code);
        st = ST_DROP;
        queue_result(KIND_ERROR, 8'd0, 32'd0, 1'b0, code);
    endtask

    // Judge a fully decoded length: limit first, then the mask bit
    task automatic length_known();
        if (frame_len > {32'd0, limit})
            raise_error(ERR_TOO_LONG);
        else if (masked)
        begin
            st       = ST_KEY;
            key_seen = '0;
            key      = '0;
        end
        else if (frame_len != 64'd0)
            raise_error(ERR_NO_MASK);
        else
        begin
            st = ST_HDR0;
            queue_result(KIND_HEADER, 8'd0, 32'd0, 1'b0, '0);
        end
    endtask

    // Advance the shadow parser by one accepted byte
    task automatic parse_byte(input logic [7:0] b, input logic start);
        logic [7:0] kb;
        logic       last;
        if (start)
            st = ST_HDR0;
        case (st)
            ST_HDR0:
            begin
                opcode    = b[3:0];
                masked    = 1'b0;
                len_code  = '0;
                ext_seen  = '0;
                frame_len = '0;
                key       = '0;
                key_seen  = '0;
                data_cnt  = '0;
                // FIN is judged before the RSV bits
                if (!b[7])
                    raise_error(ERR_FIN_CLEAR);
                else if (b[6:4] != 3'd0)
                    raise_error(ERR_RSV_SET);
                else
                    st = ST_HDR1;
            end
            ST_HDR1:
            begin
                masked   = b[7];
                len_code = b[6:0];
                if (len_code < LEN_CODE_16)
                begin
                    frame_len = {57'd0, len_code};
                    length_known();
                end
                else
                begin
                    frame_len = '0;
                    ext_seen  = '0;
                    st        = ST_EXTLEN;
                end
            end
            ST_EXTLEN:
            begin
                // Big-endian accumulate; eight bytes wrap the counter back to zero
                frame_len = {frame_len[55:0], b};
                ext_seen  = ext_seen + 3'd1;
                if (ext_seen == ((len_code == LEN_CODE_16) ? 3'd2 : 3'd0))
                    length_known();
            end
            ST_KEY:
            begin
                key      = {key[23:0], b};
                key_seen = key_seen + 2'd1;
                if (key_seen == 2'd0)
                begin
                    // An empty frame takes any key
                    if (frame_len != 64'd0 && (key == 32'h0 || key == 32'hFFFF_FFFF))
                        raise_error(ERR_DEGEN_MASK);
                    else
                    begin
                        data_cnt = '0;
                        st       = (frame_len != 64'd0) ? ST_DATA : ST_HDR0;
                        queue_result(KIND_HEADER, 8'd0, frame_len[31:0], 1'b0, '0);
                    end
                end
            end
            ST_DATA:
            begin
                kb       = key[8 * (3 - data_cnt[1:0]) +: 8];
                last     = (({32'd0, data_cnt} + 64'd1) >= frame_len);
                data_cnt = data_cnt + 32'd1;
                if (last)
                    st = ST_HDR0;
                queue_result(KIND_PAYLOAD, b ^ kb, frame_len[31:0], last, '0);
            end
            default:
                st = ST_DROP;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st        = ST_HDR0;
            opcode    = '0;
            masked    = 1'b0;
            len_code  = '0;
            ext_seen  = '0;
            frame_len = '0;
            key       = '0;
            key_seen  = '0;
            data_cnt  = '0;
            limit     = MAX_PAYLOAD_INIT;
            expected_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare a returned request with the oldest expectation
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result: result_kind %0d with nothing expected",
                           result_ch.result_kind);
                    fail_cnt++;
                end
                else
                begin
                    head = expected_q.pop_front();
                    check_field("result_kind", head.result_kind, result_ch.result_kind);
                    check_field("payload_byte", head.payload_byte, result_ch.payload_byte);
                    check_field("frame_opcode", head.frame_opcode, result_ch.frame_opcode);
                    check_field("frame_length", head.frame_length, result_ch.frame_length);
                    check_field("last_byte", head.last_byte, result_ch.last_byte);
                    check_field("error_code", head.error_code, result_ch.error_code);
                end
            end
            // Predict from an accepted byte request
            if (byte_ch.valid && byte_ch.ready)
                parse_byte(byte_ch.stream_byte, byte_ch.frame_start);
            // Track limit writes and check read-back
            if (psel && penable && pready && paddr == MAX_PAYLOAD_ADDR)
            begin
                if (pwrite)
                    limit = pwdata;
                else
                    check_field("prdata", limit, prdata);
            end
            mismatches  <= fail_cnt;
            outstanding <= expected_q.size();
        end
    end

endmodule

>>> sim/websocket_frame_deframer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the WebSocket frame deframer: byte stimulus, pacing and verdict.
module websocket_frame_deframer_tb;
    import wsd_pkg::*;

    localparam int                 RANDOM_BYTES     = 1750;
    localparam int                 PHASES           = 6;
    localparam int                 MAX_GAP          = 6;
    localparam int                 FULL_PAYLOAD_MAX = 300;
    localparam int                 WATCHDOG_LIMIT   = 1000;
    localparam logic [PADDR_W-1:0] MAX_PAYLOAD_ADDR = PADDR_W'(4 * int'(REG_MAX_PAYLOAD));
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR    = PADDR_W'(4 * (int'(REG_MAX_PAYLOAD) + 1));
    localparam logic [6:0]         LEN_CODE_16      = 7'd126;
    localparam logic [6:0]         LEN_CODE_64      = 7'd127;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    int                 mismatches;
    int                 outstanding;

    wsd_in_if  byte_if ();
    wsd_out_if result_if ();

    logic [31:0] cfg_limit;
    int          bytes_sent   = 0;
    int          send_run     = 0;
    bit          send_gapless = 1'b0;
    bit          restart_next = 1'b1;

    websocket_frame_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .byte_ch   (byte_if),
        .result_ch (result_if)
    );

    wsd_frame_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .byte_ch     (byte_if),
        .result_ch   (result_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte request after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        if (send_run == 0)
        begin
            send_run     = $urandom_range(8, 64);
            send_gapless = ($urandom_range(0, 3) == 0);
        end
        send_run--;
        gap = send_gapless ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_if.valid       <= 1'b1;
        byte_if.stream_byte <= b;
        byte_if.frame_start <= start;
        @(posedge clk);
        while (!byte_if.ready) @(posedge clk);
        bytes_sent++;
    endtask

    // Drop valid, drain every expected result, then let the pipeline settle
    task automatic settle(input int cycles);
        byte_if.valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limit(input logic [31:0] value);
        settle(4);
        apb_access(1'b1, MAX_PAYLOAD_ADDR, value);
        cfg_limit = value;
        apb_access(1'b0, MAX_PAYLOAD_ADDR, 32'd0);
    endtask

    // Build one frame (mostly well formed, some broken) and stream it
    task automatic send_random_frame();
        logic [7:0]  frame[$];
        logic [7:0]  hdr0;
        logic [63:0] len;
        logic [31:0] key;
        logic        masked;
        logic        start;
        logic        doomed;
        int          pick;
        int          len_bytes;
        int          n_pay;
        int          keep;
        pick  = $urandom_range(0, 99);
        start = restart_next || ($urandom_range(0, 5) != 0);

        // Line noise with sporadic restart marks
        if (pick < 6)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
            restart_next = 1'b1;
            return;
        end

        hdr0 = {1'b1, 3'b000, 4'($urandom_range(0, 15))};
        if (pick < 10)
        begin
            hdr0[7]   = 1'b0;
            hdr0[6:4] = 3'($urandom);
        end
        else if (pick < 14)
            hdr0[6:4] = 3'($urandom_range(1, 7));
        masked = !(pick >= 14 && pick < 19);

        // Length: mostly short, sometimes huge or right at the limit
        case ($urandom_range(0, 9))
            0:             len = 64'd0;
            1, 2, 3, 4, 5: len = 64'($urandom_range(1, 20));
            6:             len = 64'($urandom_range(21, FULL_PAYLOAD_MAX));
            7:             len = 64'($urandom);
            8:             len = {$urandom, $urandom};
            default:       len = 64'(cfg_limit) + 64'($urandom_range(0, 2)) - 64'd1;
        endcase

        // Encoding, sometimes a longer form than needed
        if (len < 64'd126)
            len_bytes = ($urandom_range(0, 9) < 7) ? 0 : ($urandom_range(0, 1) ? 2 : 8);
        else if (len < 64'd65536)
            len_bytes = ($urandom_range(0, 3) == 0) ? 8 : 2;
        else
            len_bytes = 8;

        frame.push_back(hdr0);
        case (len_bytes)
            0:       frame.push_back({masked, len[6:0]});
            2:       frame.push_back({masked, LEN_CODE_16});
            default: frame.push_back({masked, LEN_CODE_64});
        endcase
        for (int i = len_bytes - 1; i >= 0; i--)
            frame.push_back(len[8 * i +: 8]);

        // Key: mostly random, sometimes all zero, all ones or a zero/ones mix
        key = $urandom;
        case ($urandom_range(0, 19))
            0:       key = 32'h0;
            1:       key = 32'hFFFF_FFFF;
            2:       for (int i = 0; i < 4; i++)
                         key[8 * i +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        if (masked)
            for (int i = 3; i >= 0; i--)
                frame.push_back(key[8 * i +: 8]);

        doomed = !hdr0[7] || (hdr0[6:4] != 3'd0) || (len > 64'(cfg_limit)) ||
                 (len != 64'd0 && (!masked || key == 32'h0 || key == 32'hFFFF_FFFF));

        // Whole payload when it fits, a few trailing bytes otherwise
        if (doomed)
            n_pay = $urandom_range(0, 3);
        else if (len <= FULL_PAYLOAD_MAX)
            n_pay = int'(len);
        else
            n_pay = $urandom_range(0, 8);
        repeat (n_pay) frame.push_back(8'($urandom));

        // Cut a bad first byte short, and now and then a good frame too
        keep = frame.size();
        if (!hdr0[7] || hdr0[6:4] != 3'd0)
            keep = $urandom_range(1, 3);
        else if ($urandom_range(0, 19) == 0)
            keep = $urandom_range(1, frame.size());
        if (keep > frame.size())
            keep = frame.size();

        restart_next = doomed || (keep < frame.size()) || (n_pay < len);
        for (int i = 0; i < keep; i++)
            send_byte(frame[i], (i == 0) ? start : 1'b0);
    endtask

    // Result side: random stall before each request, with stall-free runs
    initial
    begin
        int stall;
        int run_left;
        bit no_stall;
        run_left = 0;
        no_stall = 1'b0;
        result_if.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(8, 48);
                no_stall = ($urandom_range(0, 3) == 0);
            end
            run_left--;
            stall = no_stall ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid) @(posedge clk);
        end
    end

    // Watchdog: end the run after too long without any transfer
    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((byte_if.valid && byte_if.ready) || (result_if.valid && result_if.ready) ||
                (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        int random_base;
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        byte_if.valid       <= 1'b0;
        byte_if.stream_byte <= '0;
        byte_if.frame_start <= 1'b0;
        cfg_limit = MAX_PAYLOAD_INIT;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // FIN clear with RSV bits set: FIN is reported
        send_byte(8'h72, 1'b1);
        // RSV set
        send_byte(8'hC1, 1'b1);
        // Unmasked empty ping: header right after the length byte
        send_byte(8'h89, 1'b1);
        send_byte(8'h00, 1'b0);
        // Unmasked nonempty, taken between frames without a restart mark
        send_byte(8'h82, 1'b0);
        send_byte(8'h05, 1'b0);
        // Masked empty close: all-zero key still consumed and not judged
        send_byte(8'h88, 1'b1);
        send_byte(8'h80, 1'b0);
        repeat (4) send_byte(8'h00, 1'b0);
        // Degenerate keys on one-byte frames
        send_byte(8'h81, 1'b1);
        send_byte(8'h81, 1'b0);
        repeat (4) send_byte(8'h00, 1'b0);
        send_byte(8'h8A, 1'b1);
        send_byte(8'h81, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);

        // Random frames under a sequence of limit settings
        random_base  = bytes_sent;
        restart_next = 1'b1;
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1: set_limit(32'd0);
                2: set_limit(32'hFFFF_FFFF);
                3: set_limit(32'd40);
                4: set_limit(32'($urandom_range(1, FULL_PAYLOAD_MAX)));
                5:
                begin
                    settle(4);
                    apb_access(1'b1, UNMAPPED_ADDR, $urandom);
                    set_limit($urandom);
                end
                default:
                begin
                    settle(4);
                    apb_access(1'b0, MAX_PAYLOAD_ADDR, 32'd0);
                end
            endcase
            while (bytes_sent < random_base + (p + 1) * RANDOM_BYTES / PHASES)
                send_random_frame();
        end

        settle(10);
        if (mismatches == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> websocket_frame_deframer.f
rtl/wsd_pkg.sv
rtl/wsd_in_if.sv
rtl/wsd_out_if.sv
rtl/wsd_parser.sv
rtl/wsd_out_buf.sv
rtl/websocket_frame_deframer.sv
sim/wsd_frame_checker.sv
sim/websocket_frame_deframer_tb.sv
